[rtl/sptri_pkg.sv]
// ----------------------------------------------------------------------------
// sptri_pkg
// Shared types and constants for the sphere projection trilateration block.
// ----------------------------------------------------------------------------
package sptri_pkg;

    // Default coordinate width and fixed register widths.
    localparam int COORD_W   = 24;
    localparam int RANGE_W   = 23;
    localparam int CFG_IDX_W = 2;

    // Register reset values (Q11.12 meters).
    localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 23'd4096;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 23'd40960;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 2'd1;

    // Result status codes.
    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    // Datapath operations.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR,
        OP_MUL,
        OP_ACC,
        OP_PROD,
        OP_CHK_LO,
        OP_CHK_HI,
        OP_SQ_LD,
        OP_SQ_STEP,
        OP_SQ_R,
        OP_SQ_D,
        OP_DV_LD,
        OP_DV_STEP,
        OP_APPLY,
        OP_COMMIT,
        OP_RESULT
    } dp_op_t;

    // Multiplier operand selection.
    typedef enum logic [2:0] {
        SEL_OFF,
        SEL_DIFF,
        SEL_MIN,
        SEL_MAX,
        SEL_NUM
    } mul_sel_t;

    // Command from controller to datapath.
    typedef struct packed {
        dp_op_t     op;
        mul_sel_t   sel;
        logic [1:0] axis;
        logic [1:0] stat;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic win_ok;
        logic at_beacon;
        logic last;
    } dp_stat_t;

endpackage

[rtl/sphere_projection_trilateration.sv]
// ----------------------------------------------------------------------------
// sphere_projection_trilateration
// Moves the kept 3-D position estimate onto the sphere of the measured range
// around each beacon, one word at a time.
//
// Channel  Direction  Handshake                Word
// s_axis   in         s_axis_tvalid/tready     offset and beacon position
// m_axis   out        m_axis_tvalid/tready     estimate and status
// cfg      in         cfg_valid/cfg_ready      register index and value
//
// One word at a time. An updated word passes through the two bit-serial square
// roots and the bit-serial divider between accept and result; a word outside the
// range window or at zero distance skips them.
// The next word can be taken in the cycle after the result register is loaded.
// The output register lets the next word start while a result waits.
// Reset sets the estimate to zero and the window to 1.0 m .. 10.0 m.
// ----------------------------------------------------------------------------
module sphere_projection_trilateration #(
    parameter  int COORD_WIDTH = sptri_pkg::COORD_W,
    localparam int IN_W        = ((6 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W       = ((3 * COORD_WIDTH + 2 + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // offset_x, offset_y, offset_z, beacon_x, beacon_y, beacon_z, zero pad
    input  logic [IN_W-1:0]                     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // est_x, est_y, est_z, status, zero pad
    output logic [OUT_W-1:0]                    m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sptri_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sptri_pkg::RANGE_W-1:0]       cfg_data
);
    import sptri_pkg::*;

    localparam int CW = COORD_WIDTH;

    cmd_t                 cmd;
    dp_stat_t             stat;
    logic signed [CW-1:0] in_off [3];
    logic signed [CW-1:0] in_bcn [3];
    logic signed [CW-1:0] est [3];
    logic [1:0]           est_status;

    // Unpack the input word.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_off[i] = s_axis_tdata[i*CW +: CW];
            in_bcn[i] = s_axis_tdata[(i+3)*CW +: CW];
        end
    end

    // Pack the result word.
    assign m_axis_tdata = OUT_W'({est_status, est[2], est[1], est[0]});
    assign cfg_ready    = 1'b1;

    sptri_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    sptri_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_idx    (cfg_index),
        .cfg_val    (cfg_data),
        .in_off     (in_off),
        .in_bcn     (in_bcn),
        .est        (est),
        .est_status (est_status)
    );

endmodule

[rtl/sptri_dp.sv]
// ----------------------------------------------------------------------------
// sptri_dp
// Datapath: shared multiplier with accumulator, bit-serial square root,
// bit-serial divider, projection and saturation, estimate and config regs.
// ----------------------------------------------------------------------------
module sptri_dp #(
    parameter int COORD_WIDTH = sptri_pkg::COORD_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sptri_pkg::cmd_t                     cmd,
    output sptri_pkg::dp_stat_t                 stat,
    input  logic                                cfg_we,
    input  logic [sptri_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [sptri_pkg::RANGE_W-1:0]       cfg_val,
    input  logic signed [COORD_WIDTH-1:0]       in_off [3],
    input  logic signed [COORD_WIDTH-1:0]       in_bcn [3],
    output logic signed [COORD_WIDTH-1:0]       est [3],
    output logic [1:0]                          est_status
);
    import sptri_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int OPW  = (CW + 1 > RANGE_W) ? CW + 1 : RANGE_W;
    localparam int SW   = 2 * OPW + 2;
    localparam int K    = OPW + 1;
    localparam int NW   = 2 * OPW;
    localparam int CNTW = $clog2(NW);

    localparam logic signed [CW+2:0] V_HI = {4'b0000, {(CW-1){1'b1}}};
    localparam logic signed [CW+2:0] V_LO = {4'b1111, {(CW-1){1'b0}}};

    logic signed [CW-1:0] off_reg [3];
    logic signed [CW-1:0] bcn_reg [3];
    logic signed [CW-1:0] pos_reg [3];
    logic signed [CW-1:0] new_reg [3];
    logic signed [CW-1:0] est_reg [3];
    logic [1:0]           est_st_reg;
    logic [RANGE_W-1:0]   min_reg;
    logic [RANGE_W-1:0]   max_reg;
    logic [SW-1:0]        acc_reg;
    logic [NW-1:0]        prod_reg;
    logic                 win_reg;
    logic                 sat_reg;
    logic [SW-1:0]        rad_reg;
    logic [K-1:0]         root_reg;
    logic [K+1:0]         rem_reg;
    logic [OPW-1:0]       r_reg;
    logic [OPW-1:0]       d_reg;
    logic [NW-1:0]        num_reg;
    logic [NW-1:0]        quo_reg;
    logic [OPW:0]         drem_reg;
    logic [CNTW-1:0]      cnt_reg;

    // Differences and magnitudes.
    logic signed [CW:0] dif [3];
    logic [CW:0]        dif_mag [3];
    logic [CW-1:0]      off_mag [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dif[i]     = {pos_reg[i][CW-1], pos_reg[i]} - {bcn_reg[i][CW-1], bcn_reg[i]};
            dif_mag[i] = dif[i][CW] ? (CW+1)'(-dif[i]) : dif[i];
            off_mag[i] = off_reg[i][CW-1] ? CW'(-off_reg[i]) : off_reg[i];
        end
    end

    // Shared multiplier operand selection.
    logic [OPW-1:0] mul_a;
    logic [OPW-1:0] mul_b;
    logic [NW-1:0]  mul_p;

    always_comb
    begin
        case (cmd.sel)
            SEL_OFF:
            begin
                mul_a = OPW'(off_mag[cmd.axis]);
                mul_b = OPW'(off_mag[cmd.axis]);
            end
            SEL_DIFF:
            begin
                mul_a = OPW'(dif_mag[cmd.axis]);
                mul_b = OPW'(dif_mag[cmd.axis]);
            end
            SEL_MIN:
            begin
                mul_a = OPW'(min_reg);
                mul_b = OPW'(min_reg);
            end
            SEL_MAX:
            begin
                mul_a = OPW'(max_reg);
                mul_b = OPW'(max_reg);
            end
            SEL_NUM:
            begin
                mul_a = OPW'(dif_mag[cmd.axis]);
                mul_b = r_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Square root step: two radicand bits per cycle.
    logic [K+1:0] sq_cand;
    logic [K+1:0] sq_trial;
    logic         sq_ge;
    logic [K-1:0] root_rnd;

    assign sq_cand  = {rem_reg[K-1:0], rad_reg[SW-1:SW-2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = sq_cand >= sq_trial;
    assign root_rnd = root_reg + K'(rem_reg > {2'b00, root_reg});

    // Divider step: one quotient bit per cycle.
    logic [OPW:0] dv_cand;
    logic         dv_ge;

    assign dv_cand = {drem_reg[OPW-1:0], num_reg[NW-1]};
    assign dv_ge   = dv_cand >= {1'b0, d_reg};

    // Rounding, projection and saturation of one axis.
    logic                 q_up;
    logic [NW:0]          q_rnd;
    logic                 q_big;
    logic signed [CW+2:0] b_ext;
    logic signed [CW+2:0] q_ext;
    logic signed [CW+2:0] v_sum;
    logic signed [CW-1:0] v_out;
    logic                 v_sat;

    always_comb
    begin
        q_up  = drem_reg >= ({1'b0, d_reg} - drem_reg);
        q_rnd = {1'b0, quo_reg} + (NW+1)'(q_up);
        q_big = |q_rnd[NW:CW+1];
        b_ext = (CW+3)'(bcn_reg[cmd.axis]);
        q_ext = {2'b00, q_rnd[CW:0]};
        v_sum = dif[cmd.axis][CW] ? b_ext - q_ext : b_ext + q_ext;
        v_sat = 1'b1;
        if (q_big)
        begin
            v_out = dif[cmd.axis][CW] ? CW'(V_LO) : CW'(V_HI);
        end
        else if (v_sum > V_HI)
        begin
            v_out = CW'(V_HI);
        end
        else if (v_sum < V_LO)
        begin
            v_out = CW'(V_LO);
        end
        else
        begin
            v_out = CW'(v_sum);
            v_sat = 1'b0;
        end
    end

    // Control state: estimate and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            pos_reg[2] <= '0;
            min_reg    <= MIN_RANGE_RST;
            max_reg    <= MAX_RANGE_RST;
        end
        else
        begin
            if (cfg_we && cfg_idx == CFG_MIN_RANGE)
            begin
                min_reg <= cfg_val;
            end
            if (cfg_we && cfg_idx == CFG_MAX_RANGE)
            begin
                max_reg <= cfg_val;
            end
            if (cmd.op == OP_COMMIT)
            begin
                pos_reg <= new_reg;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                off_reg  <= in_off;
                bcn_reg  <= in_bcn;
                acc_reg  <= '0;
                prod_reg <= '0;
                sat_reg  <= 1'b0;
            end
            OP_CLR:
            begin
                acc_reg  <= '0;
                prod_reg <= '0;
            end
            OP_MUL:
            begin
                acc_reg  <= acc_reg + SW'(prod_reg);
                prod_reg <= mul_p;
            end
            OP_ACC:
            begin
                acc_reg  <= acc_reg + SW'(prod_reg);
                prod_reg <= '0;
            end
            OP_PROD:
            begin
                prod_reg <= mul_p;
            end
            OP_CHK_LO:
            begin
                win_reg <= SW'(prod_reg) <= acc_reg;
            end
            OP_CHK_HI:
            begin
                win_reg <= win_reg && (acc_reg <= SW'(prod_reg));
            end
            OP_SQ_LD:
            begin
                rad_reg  <= acc_reg;
                root_reg <= '0;
                rem_reg  <= '0;
                cnt_reg  <= CNTW'(K - 1);
            end
            OP_SQ_STEP:
            begin
                rad_reg  <= {rad_reg[SW-3:0], 2'b00};
                root_reg <= {root_reg[K-2:0], sq_ge};
                rem_reg  <= sq_ge ? sq_cand - sq_trial : sq_cand;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            OP_SQ_R:
            begin
                r_reg <= OPW'(root_rnd);
            end
            OP_SQ_D:
            begin
                d_reg <= OPW'(root_rnd);
            end
            OP_DV_LD:
            begin
                num_reg  <= prod_reg;
                quo_reg  <= '0;
                drem_reg <= '0;
                cnt_reg  <= CNTW'(NW - 1);
            end
            OP_DV_STEP:
            begin
                num_reg  <= {num_reg[NW-2:0], 1'b0};
                quo_reg  <= {quo_reg[NW-2:0], dv_ge};
                drem_reg <= dv_ge ? dv_cand - {1'b0, d_reg} : dv_cand;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            OP_APPLY:
            begin
                new_reg[cmd.axis] <= v_out;
                sat_reg           <= sat_reg | v_sat;
            end
            OP_RESULT:
            begin
                est_reg    <= pos_reg;
                est_st_reg <= (cmd.stat == ST_UPDATED && sat_reg) ? ST_SAT : cmd.stat;
            end
            default:
            begin
            end
        endcase
    end

    // Status to the controller.
    assign stat.win_ok    = win_reg;
    assign stat.at_beacon = (pos_reg[0] == bcn_reg[0]) && (pos_reg[1] == bcn_reg[1])
                            && (pos_reg[2] == bcn_reg[2]);
    assign stat.last      = (cnt_reg == '0);

    assign est        = est_reg;
    assign est_status = est_st_reg;

endmodule

[rtl/sptri_ctrl.sv]
// ----------------------------------------------------------------------------
// sptri_ctrl
// Controller: sequences the datapath for one word and runs both handshakes.
// ----------------------------------------------------------------------------
module sptri_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output sptri_pkg::cmd_t     cmd,
    input  sptri_pkg::dp_stat_t stat
);
    import sptri_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_MOX, S_MOY, S_MOZ, S_ACC1, S_MMIN, S_CLO, S_MMAX, S_CHI, S_DEC,
        S_RLD, S_RSTEP, S_RFIN, S_DCLR, S_MDX, S_MDY, S_MDZ, S_ACC2,
        S_DLD, S_DSTEP, S_DFIN, S_MN, S_QLD, S_QSTEP, S_APPLY, S_COMMIT, S_RES
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] st_reg, st_next;
    logic       out_valid_reg, out_valid_next;
    logic       res_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign res_fire  = (state_reg == S_RES) && (!out_valid_reg || out_ready);

    // Command decode and next state.
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.sel        = SEL_OFF;
        cmd.axis       = 2'd0;
        cmd.stat       = st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MOX;
                end
            end
            S_MOX:
            begin
                cmd.op     = OP_MUL;
                state_next = S_MOY;
            end
            S_MOY:
            begin
                cmd.op     = OP_MUL;
                cmd.axis   = 2'd1;
                state_next = S_MOZ;
            end
            S_MOZ:
            begin
                cmd.op     = OP_MUL;
                cmd.axis   = 2'd2;
                state_next = S_ACC1;
            end
            S_ACC1:
            begin
                cmd.op     = OP_ACC;
                state_next = S_MMIN;
            end
            S_MMIN:
            begin
                cmd.op     = OP_PROD;
                cmd.sel    = SEL_MIN;
                state_next = S_CLO;
            end
            S_CLO:
            begin
                cmd.op     = OP_CHK_LO;
                state_next = S_MMAX;
            end
            S_MMAX:
            begin
                cmd.op     = OP_PROD;
                cmd.sel    = SEL_MAX;
                state_next = S_CHI;
            end
            S_CHI:
            begin
                cmd.op     = OP_CHK_HI;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                // Window test first, then the zero-distance check.
                if (!stat.win_ok)
                begin
                    st_next    = ST_RANGE;
                    state_next = S_RES;
                end
                else if (stat.at_beacon)
                begin
                    st_next    = ST_ZERO;
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_RLD;
                end
            end
            S_RLD:
            begin
                cmd.op     = OP_SQ_LD;
                state_next = S_RSTEP;
            end
            S_RSTEP:
            begin
                cmd.op = OP_SQ_STEP;
                if (stat.last)
                begin
                    state_next = S_RFIN;
                end
            end
            S_RFIN:
            begin
                cmd.op     = OP_SQ_R;
                state_next = S_DCLR;
            end
            S_DCLR:
            begin
                cmd.op     = OP_CLR;
                state_next = S_MDX;
            end
            S_MDX:
            begin
                cmd.op     = OP_MUL;
                cmd.sel    = SEL_DIFF;
                state_next = S_MDY;
            end
            S_MDY:
            begin
                cmd.op     = OP_MUL;
                cmd.sel    = SEL_DIFF;
                cmd.axis   = 2'd1;
                state_next = S_MDZ;
            end
            S_MDZ:
            begin
                cmd.op     = OP_MUL;
                cmd.sel    = SEL_DIFF;
                cmd.axis   = 2'd2;
                state_next = S_ACC2;
            end
            S_ACC2:
            begin
                cmd.op     = OP_ACC;
                state_next = S_DLD;
            end
            S_DLD:
            begin
                cmd.op     = OP_SQ_LD;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op = OP_SQ_STEP;
                if (stat.last)
                begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN:
            begin
                cmd.op     = OP_SQ_D;
                axis_next  = 2'd0;
                state_next = S_MN;
            end
            S_MN:
            begin
                cmd.op     = OP_PROD;
                cmd.sel    = SEL_NUM;
                cmd.axis   = axis_reg;
                state_next = S_QLD;
            end
            S_QLD:
            begin
                cmd.op     = OP_DV_LD;
                state_next = S_QSTEP;
            end
            S_QSTEP:
            begin
                cmd.op = OP_DV_STEP;
                if (stat.last)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.op   = OP_APPLY;
                cmd.axis = axis_reg;
                if (axis_reg == 2'd2)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_MN;
                end
            end
            S_COMMIT:
            begin
                cmd.op     = OP_COMMIT;
                st_next    = ST_UPDATED;
                state_next = S_RES;
            end
            S_RES:
            begin
                // Wait until the output register is free.
                if (res_fire)
                begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 2'd0;
            st_reg        <= ST_UPDATED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
